FILE: design/tlwvs_pkg.sv
// Package for the text line/word/vowel statistics block.
// Holds item types, action and result codes, sizes and character helpers.
// No dependencies.
`timescale 1ns / 1ps

package tlwvs_pkg;

  // Line buffer size: a line closes after LINE_BUFFER-1 bytes
  localparam int unsigned LINE_BUFFER = 1024;
  localparam int unsigned LINE_W      = $clog2(LINE_BUFFER);
  localparam int unsigned STORE_DEPTH = 2 * LINE_BUFFER;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_BITS  = 32;

  localparam logic [LINE_W-1:0] LAST_CHUNK = LINE_W'(LINE_BUFFER - 1);

  // Character codes
  localparam logic [7:0] CHR_NUL     = 8'h00;
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_UP_A    = 8'h41;
  localparam logic [7:0] CHR_UP_Z    = 8'h5A;
  localparam logic [7:0] CHR_LOW_A   = 8'h61;
  localparam logic [7:0] CHR_LOW_E   = 8'h65;
  localparam logic [7:0] CHR_LOW_I   = 8'h69;
  localparam logic [7:0] CHR_LOW_O   = 8'h6F;
  localparam logic [7:0] CHR_LOW_U   = 8'h75;
  localparam logic [7:0] CASE_BIT    = 8'h20;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_END  = 2'd1,
    ACT_READ = 2'd2
  } action_e;

  typedef enum logic {
    KIND_STATS = 1'b0,
    KIND_BYTE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [COUNT_BITS-1:0] line_count;
    logic [COUNT_BITS-1:0] word_count;
    logic [COUNT_BITS-1:0] vowel_count;
    logic [9:0]            longest_length;
    logic [7:0]            line_byte;
  } out_item_t;

  // Line store access request from the statistics unit
  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
  } store_req_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
  endfunction

  function automatic logic is_vowel(input logic [7:0] b);
    logic [7:0] c;
    c = ((b >= CHR_UP_A) && (b <= CHR_UP_Z)) ? (b | CASE_BIT) : b;
    return (c == CHR_LOW_A) || (c == CHR_LOW_E) || (c == CHR_LOW_I) ||
           (c == CHR_LOW_O) || (c == CHR_LOW_U);
  endfunction

endpackage

FILE: design/text_line_word_vowel_stats_core.sv
// Top level of the text line/word/vowel statistics block.
// Uses tlwvs_pkg, tlwvs_stats and tlwvs_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries one action per
//   transfer: a text byte, an end of text, or a read of the longest line.
//   Output channel (out_valid_o/out_ready_i/out_item_o) returns one result
//   for each end (statistics) and each read (one stored byte); text bytes
//   and unknown actions return nothing.
//   An accepted item lands in an input register and is processed from there;
//   when it advances, its result is loaded into the output register and
//   offered from there.
//   Throughput is one item per cycle while no held result blocks it; each
//   item uses the line store at most once (one write per visible text
//   byte, one read per read action); the store has one write, one read port.
//   When the receiver stalls, the result is held and the input register
//   still takes one more item; text bytes keep flowing past a held result,
//   only items that make a result wait behind it.
//   Reset clears counters, line state and both channels; the line store
//   is not cleared and needs no sweep, since only written bytes are read.
module text_line_word_vowel_stats_core import tlwvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  out_item_t  out_meta_q;
  logic       byte_ok_q;

  logic       produces;
  logic       advance;
  store_req_t store_req;
  out_item_t  result;
  logic       byte_ok;
  logic [7:0] rd_data;

  // An item moves on when it makes no result or the output slot frees up
  assign produces   = (in_item_q.action == ACT_END) || (in_item_q.action == ACT_READ);
  assign advance    = in_valid_q && (!produces || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  tlwvs_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .store_req_o (store_req),
    .result_o    (result),
    .byte_ok_o   (byte_ok)
  );

  // Two banks of line bytes; read data holds until the next read
  tlwvs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (store_req.wr_en),
    .wr_addr_i (store_req.wr_addr),
    .wr_data_i (store_req.wr_data),
    .rd_en_i   (store_req.rd_en),
    .rd_addr_i (store_req.rd_addr),
    .rd_data_o (rd_data)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produces) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      out_meta_q <= result;
      byte_ok_q  <= byte_ok;
    end
  end

  // Merge the stored byte into the held result
  always_comb begin
    out_item_o           = out_meta_q;
    out_item_o.line_byte = byte_ok_q ? rd_data : 8'h00;
  end

  assign out_valid_o = out_valid_q;

  // A held result's store byte must not be overwritten by a new read
  a_no_read_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !store_req.rd_en)
    else $error("line store read issued while a result is held");

  // A result-making item must not pass a held result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && produces && out_valid_q && !out_ready_i) |-> !advance)
    else $error("result overwritten while stalled");

  // Store bytes belong only to read results
  a_byte_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && byte_ok_q) |-> (out_meta_q.kind == KIND_BYTE))
    else $error("store byte attached to a statistics result");

endmodule

FILE: design/tlwvs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tlwvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: design/tlwvs_stats.sv
// Statistics unit: line/word/vowel counters, line tracking and longest-line
// bookkeeping, plus line store write and read requests. Uses tlwvs_pkg.
`timescale 1ns / 1ps

module tlwvs_stats import tlwvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_item_t   item_i,
  output store_req_t store_req_o,
  output out_item_t  result_o,
  output logic       byte_ok_o
);

  logic                  best_bank_q, best_bank_d;
  logic [LINE_W-1:0]     chunk_q, chunk_d;
  logic [LINE_W-1:0]     kept_q, kept_d;
  logic                  nul_q, nul_d;
  logic                  in_word_q, in_word_d;
  logic [COUNT_BITS-1:0] lines_q, lines_d;
  logic [COUNT_BITS-1:0] words_q, words_d;
  logic [COUNT_BITS-1:0] vowels_q, vowels_d;
  logic [LINE_W-1:0]     best_len_q, best_len_d;
  logic                  text_done_q, text_done_d;

  logic [LINE_W-1:0]     best_eff;
  logic [LINE_W-1:0]     chunk_n;
  logic                  close_line;
  logic [7:0]            b;

  assign b        = item_i.data_byte;
  assign best_eff = text_done_q ? '0 : best_len_q;
  assign chunk_n  = chunk_q + 1'b1;

  // Next state, store requests and result fields
  always_comb begin
    best_bank_d = best_bank_q;
    chunk_d     = chunk_q;
    kept_d      = kept_q;
    nul_d       = nul_q;
    in_word_d   = in_word_q;
    lines_d     = lines_q;
    words_d     = words_q;
    vowels_d    = vowels_q;
    best_len_d  = best_len_q;
    text_done_d = text_done_q;
    close_line  = 1'b0;
    store_req_o = '0;
    result_o    = '0;
    byte_ok_o   = 1'b0;

    unique case (item_i.action)
      ACT_BYTE: begin
        text_done_d = 1'b0;
        best_len_d  = best_eff;
        chunk_d     = chunk_n;
        if (b == CHR_NEWLINE) begin
          close_line = 1'b1;
        end else begin
          if (!nul_q) begin
            if (b == CHR_NUL) begin
              nul_d = 1'b1;
            end else begin
              store_req_o.wr_en   = step_i;
              store_req_o.wr_addr = {~best_bank_q, kept_q};
              store_req_o.wr_data = b;
              kept_d = kept_q + 1'b1;
              if (is_vowel(b)) begin
                vowels_d = sat_inc(vowels_q);
              end
              if (is_space(b)) begin
                in_word_d = 1'b0;
              end else if (!in_word_q) begin
                words_d   = sat_inc(words_q);
                in_word_d = 1'b1;
              end
            end
          end
          if (chunk_n >= LAST_CHUNK) begin
            close_line = 1'b1;
          end
        end
        // Close the line; strictly longer lines take over
        if (close_line) begin
          lines_d = sat_inc(lines_q);
          if (kept_d > best_eff) begin
            best_len_d  = kept_d;
            best_bank_d = ~best_bank_q;
          end
          chunk_d   = '0;
          kept_d    = '0;
          nul_d     = 1'b0;
          in_word_d = 1'b0;
        end
      end
      ACT_END: begin
        best_len_d = best_eff;
        lines_d    = lines_q;
        // Close a partial line first
        if (chunk_q != '0) begin
          lines_d = sat_inc(lines_q);
          if (kept_q > best_eff) begin
            best_len_d  = kept_q;
            best_bank_d = ~best_bank_q;
          end
          chunk_d   = '0;
          kept_d    = '0;
          nul_d     = 1'b0;
          in_word_d = 1'b0;
        end
        result_o.kind           = KIND_STATS;
        result_o.line_count     = lines_d;
        result_o.word_count     = words_q;
        result_o.vowel_count    = vowels_q;
        result_o.longest_length = 10'(best_len_d);
        lines_d     = '0;
        words_d     = '0;
        vowels_d    = '0;
        text_done_d = 1'b1;
      end
      ACT_READ: begin
        result_o.kind           = KIND_BYTE;
        result_o.longest_length = 10'(best_len_q);
        if (item_i.read_index < 10'(best_len_q)) begin
          byte_ok_o           = 1'b1;
          store_req_o.rd_en   = step_i;
          store_req_o.rd_addr = {best_bank_q, LINE_W'(item_i.read_index)};
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_bank_q <= 1'b0;
      chunk_q     <= '0;
      kept_q      <= '0;
      nul_q       <= 1'b0;
      in_word_q   <= 1'b0;
      lines_q     <= '0;
      words_q     <= '0;
      vowels_q    <= '0;
      best_len_q  <= '0;
      text_done_q <= 1'b0;
    end else if (step_i) begin
      best_bank_q <= best_bank_d;
      chunk_q     <= chunk_d;
      kept_q      <= kept_d;
      nul_q       <= nul_d;
      in_word_q   <= in_word_d;
      lines_q     <= lines_d;
      words_q     <= words_d;
      vowels_q    <= vowels_d;
      best_len_q  <= best_len_d;
      text_done_q <= text_done_d;
    end
  end

  // Visible bytes never outrun bytes taken into the line
  a_kept_le_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= chunk_q)
    else $error("visible count exceeds line byte count");

  // A full line must have been closed
  a_chunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_q < LAST_CHUNK)
    else $error("line byte count reached the line limit");

  // Counters are cleared once a text is closed
  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_done_q |-> (lines_q == '0 && words_q == '0 && vowels_q == '0))
    else $error("counters not cleared after end of text");

endmodule
